// ----- src/dpsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpsm_pkg
// Shared widths, register indexes, reset values and types for the score mapper.
// ----------------------------------------------------------------------------
package dpsm_pkg;

	localparam int ELEM_W  = 16;
	localparam int PROD_W  = 32;
	localparam int ACC_W   = 48;
	localparam int S_W     = 33;
	localparam int DIFF_W  = 34;
	localparam int SLOPE_W = 16;
	localparam int MUL_W   = 51;
	localparam int VSUM_W  = 52;
	localparam int V_W     = 29;
	localparam int PCT_W   = 45;
	localparam int SCORE_W = 16;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_BOUND_ONE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_BOUND_TWO   = 3'd1;
	localparam logic [IDX_W-1:0] REG_BOUND_THREE = 3'd2;
	localparam logic [IDX_W-1:0] REG_SLOPE_ZERO  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SLOPE_ONE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SLOPE_TWO   = 3'd5;
	localparam logic [IDX_W-1:0] REG_SLOPE_THREE = 3'd6;

	localparam logic [15:0] RST_BOUND_ONE   = 16'd14090;
	localparam logic [15:0] RST_BOUND_TWO   = 16'd16384;
	localparam logic [15:0] RST_BOUND_THREE = 16'd18022;
	localparam logic [15:0] RST_SLOPE_ZERO  = 16'd1432;
	localparam logic [15:0] RST_SLOPE_ONE   = 16'd11703;
	localparam logic [15:0] RST_SLOPE_TWO   = 16'd16384;
	localparam logic [15:0] RST_SLOPE_THREE = 16'd910;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic signed [DIFF_W-1:0] X_LOW  = -34'sd32768;
	localparam logic signed [DIFF_W-1:0] X_HIGH = 34'sd32768;

	localparam logic signed [V_W-1:0]    ONE_V    = 29'sd134217728;
	localparam logic signed [VSUM_W-1:0] ONE_WIDE = 52'sd134217728;
	localparam logic signed [15:0]       PCT_FULL = 16'sd25600;
	localparam logic signed [PCT_W-1:0]  PCT_HALF = 45'sd67108864;

	typedef struct packed {
		logic [2:0][ELEM_W-1:0]  bound;
		logic [3:0][SLOPE_W-1:0] slope;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mac;
		logic seg;
		logic diff;
		logic mul;
		logic clamp;
		logic pct;
	} cmd_t;

	// segment start levels, Q.27
	function automatic logic [V_W-1:0] seg_y(input logic [1:0] seg);
		logic [V_W-1:0] y;
		unique case (seg)
			2'd0: y = 29'd0;
			2'd1: y = 29'd67108864;
			2'd2: y = 29'd93952410;
			2'd3: y = 29'd120795955;
			default: y = 29'd0;
		endcase
		return y;
	endfunction

endpackage

// ----- src/dpsm_if.sv -----
// ----------------------------------------------------------------------------
// dpsm_if
// Valid/ready channels: element pairs in, scores out, register writes in.
// ----------------------------------------------------------------------------
interface dpsm_feat_if;
	import dpsm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [ELEM_W-1:0] elem_a;
	logic signed [ELEM_W-1:0] elem_b;
	logic                     last;
	modport source (output valid, elem_a, elem_b, last, input ready);
	modport sink   (input valid, elem_a, elem_b, last, output ready);
endinterface

interface dpsm_score_if;
	import dpsm_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score_percent;
	modport source (output valid, score_percent, input ready);
	modport sink   (input valid, score_percent, output ready);
endinterface

interface dpsm_cfg_if;
	import dpsm_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [15:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/dot_product_score_mapper.sv -----
// ----------------------------------------------------------------------------
// dot_product_score_mapper
// Dot product of two Q1.15 vectors mapped through a piecewise-linear curve.
// ----------------------------------------------------------------------------
// feat:  one element pair per beat (elem_a, elem_b, last). Pairs are taken
//        one per cycle while ready; products feed a 48-bit saturating sum.
// score: one beat per vector, score_percent in signed Q8.8, +-100%.
// cfg:   register writes, index 0..6 (breakpoints, then slopes), always
//        ready; unknown indexes are dropped. Write only while idle.
// After the beat marked last the result goes through MAC flush, segment
// select, offset, slope multiply, clamp and scaling. feat is not ready
// from the last beat until the scaling step has loaded the output register,
// so the next vector's pairs wait for that step.
// A result waiting on score does not block the next vector's pairs; only
// the following result's scaling step waits for the output register.
// Reset: accumulator cleared, registers at their calibration defaults,
// no score pending.
// ----------------------------------------------------------------------------
module dot_product_score_mapper (
	input  logic       clk,
	input  logic       arst_n,
	dpsm_feat_if.sink  feat,
	dpsm_score_if.source score,
	dpsm_cfg_if.sink   cfg
);
	import dpsm_pkg::*;

	cfg_t regs;
	cmd_t cmd;

	dpsm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dpsm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.feat_valid  (feat.valid),
		.feat_last   (feat.last),
		.feat_ready  (feat.ready),
		.score_valid (score.valid),
		.score_ready (score.ready),
		.cmd         (cmd)
	);

	dpsm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.regs          (regs),
		.elem_a        (feat.elem_a),
		.elem_b        (feat.elem_b),
		.score_percent (score.score_percent)
	);

endmodule

// ----- src/dpsm_cfg.sv -----
// ----------------------------------------------------------------------------
// dpsm_cfg
// Calibration register file: breakpoints and slopes, written one beat at a time.
// ----------------------------------------------------------------------------
module dpsm_cfg (
	input  logic          clk,
	input  logic          arst_n,
	dpsm_cfg_if.sink      cfg,
	output dpsm_pkg::cfg_t regs
);
	import dpsm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.bound[0] <= RST_BOUND_ONE;
			regs_q.bound[1] <= RST_BOUND_TWO;
			regs_q.bound[2] <= RST_BOUND_THREE;
			regs_q.slope[0] <= RST_SLOPE_ZERO;
			regs_q.slope[1] <= RST_SLOPE_ONE;
			regs_q.slope[2] <= RST_SLOPE_TWO;
			regs_q.slope[3] <= RST_SLOPE_THREE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_BOUND_ONE:   regs_q.bound[0] <= cfg.data;
				REG_BOUND_TWO:   regs_q.bound[1] <= cfg.data;
				REG_BOUND_THREE: regs_q.bound[2] <= cfg.data;
				REG_SLOPE_ZERO:  regs_q.slope[0] <= cfg.data;
				REG_SLOPE_ONE:   regs_q.slope[1] <= cfg.data;
				REG_SLOPE_TWO:   regs_q.slope[2] <= cfg.data;
				REG_SLOPE_THREE: regs_q.slope[3] <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/dpsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpsm_ctrl
// Sequencer: streams pairs into the MAC, then steps the calibration datapath.
// ----------------------------------------------------------------------------
module dpsm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          feat_valid,
	input  logic          feat_last,
	output logic          feat_ready,
	output logic          score_valid,
	input  logic          score_ready,
	output dpsm_pkg::cmd_t cmd
);
	import dpsm_pkg::*;

	localparam logic [2:0] ST_RUN   = 3'd0;
	localparam logic [2:0] ST_FLUSH = 3'd1;
	localparam logic [2:0] ST_SEG   = 3'd2;
	localparam logic [2:0] ST_DIFF  = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_CLAMP = 3'd5;
	localparam logic [2:0] ST_PCT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       prod_vld_q;
	logic       out_vld_q;
	logic       accept;
	logic       out_free;

	assign feat_ready  = (state_q == ST_RUN);
	assign accept      = feat_valid && feat_ready;
	assign score_valid = out_vld_q;
	assign out_free    = !out_vld_q || score_ready;

	always_comb begin
		cmd       = '0;
		cmd.load  = accept;
		cmd.mac   = prod_vld_q;
		cmd.seg   = (state_q == ST_SEG);
		cmd.diff  = (state_q == ST_DIFF);
		cmd.mul   = (state_q == ST_MUL);
		cmd.clamp = (state_q == ST_CLAMP);
		cmd.pct   = (state_q == ST_PCT) && out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:   if (accept && feat_last) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_SEG;
			ST_SEG:   state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_PCT;
			ST_PCT:   if (out_free) state_d = ST_RUN;
			default:  state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			prod_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			prod_vld_q <= accept;
			priority if (cmd.pct) out_vld_q <= 1'b1;
			else if (score_ready) out_vld_q <= 1'b0;
		end
	end

endmodule

// ----- src/dpsm_dp.sv -----
// ----------------------------------------------------------------------------
// dpsm_dp
// Datapath: product register, saturating 48-bit accumulator, segment select,
// slope multiply, clamp and percentage scaling.
// ----------------------------------------------------------------------------
module dpsm_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dpsm_pkg::cmd_t                 cmd,
	input  dpsm_pkg::cfg_t                 regs,
	input  logic signed [dpsm_pkg::ELEM_W-1:0] elem_a,
	input  logic signed [dpsm_pkg::ELEM_W-1:0] elem_b,
	output logic signed [dpsm_pkg::SCORE_W-1:0] score_percent
);
	import dpsm_pkg::*;

	logic signed [PROD_W-1:0]  p_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W:0]     sum;
	logic signed [ACC_W-1:0]   sum_sat;
	logic signed [S_W-1:0]     s;
	logic signed [S_W-1:0]     s_q;
	logic [1:0]                seg;
	logic [1:0]                seg_q;
	logic                      over;
	logic                      over_q;
	logic signed [DIFF_W-1:0]  s_ext;
	logic signed [DIFF_W-1:0]  x1;
	logic signed [DIFF_W-1:0]  x2;
	logic signed [DIFF_W-1:0]  x3;
	logic signed [DIFF_W-1:0]  x_start;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [SLOPE_W-1:0]        k_q;
	logic [V_W-1:0]            y_q;
	logic signed [SLOPE_W:0]   k_s;
	logic signed [MUL_W-1:0]   m_q;
	logic signed [VSUM_W-1:0]  vsum;
	logic signed [V_W-1:0]     v_q;
	logic signed [PCT_W-1:0]   mp;
	logic signed [PCT_W-1:0]   t;
	logic signed [SCORE_W-1:0] score_q;

	assign sum = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-PROD_W){p_s1[PROD_W-1]}}, p_s1};

	always_comb begin
		priority if (sum[ACC_W] != sum[ACC_W-1]) begin
			sum_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	// floor of acc / 2^15
	assign s     = acc_q[ACC_W-1:ACC_W-S_W];
	assign s_ext = {{(DIFF_W-S_W){s[S_W-1]}}, s};
	assign x1    = {{(DIFF_W-ELEM_W){regs.bound[0][ELEM_W-1]}}, regs.bound[0]};
	assign x2    = {{(DIFF_W-ELEM_W){regs.bound[1][ELEM_W-1]}}, regs.bound[1]};
	assign x3    = {{(DIFF_W-ELEM_W){regs.bound[2][ELEM_W-1]}}, regs.bound[2]};

	always_comb begin
		over = 1'b0;
		priority if (s_ext <= x1) seg = 2'd0;
		else if (s_ext <= x2) seg = 2'd1;
		else if (s_ext <= x3) seg = 2'd2;
		else if (s_ext <= X_HIGH) seg = 2'd3;
		else begin
			seg  = 2'd3;
			over = 1'b1;
		end
	end

	always_comb begin
		unique case (seg_q)
			2'd0: x_start = X_LOW;
			2'd1: x_start = x1;
			2'd2: x_start = x2;
			2'd3: x_start = x3;
			default: x_start = X_LOW;
		endcase
	end

	assign k_s  = {1'b0, k_q};
	assign vsum = {{(VSUM_W-V_W){1'b0}}, y_q} + {m_q[MUL_W-1], m_q};
	assign mp   = v_q * PCT_FULL;
	assign t    = mp + PCT_HALF;

	assign score_percent = score_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			priority if (cmd.seg) acc_q <= '0;
			else if (cmd.mac) acc_q <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) p_s1 <= elem_a * elem_b;
		if (cmd.seg) begin
			s_q    <= s;
			seg_q  <= seg;
			over_q <= over;
		end
		if (cmd.diff) begin
			diff_q <= {{(DIFF_W-S_W){s_q[S_W-1]}}, s_q} - x_start;
			k_q    <= regs.slope[seg_q];
			y_q    <= seg_y(seg_q);
		end
		if (cmd.mul) m_q <= diff_q * k_s;
		if (cmd.clamp) begin
			priority if (over_q) v_q <= ONE_V;
			else if (vsum > ONE_WIDE) v_q <= ONE_V;
			else if (vsum < -ONE_WIDE) v_q <= -ONE_V;
			else v_q <= vsum[V_W-1:0];
		end
		if (cmd.pct) score_q <= t[SCORE_W+26:27];
	end

endmodule
